>>> src/dhtwm_pkg.sv
// ----------------------------------------------------------------------------
// dhtwm_pkg
// Types and constants shared by the single-wire humidity sensor master.
// ----------------------------------------------------------------------------
package dhtwm_pkg;

    localparam int BITS_PER_READ = 8;
    localparam int IN_W          = 8;
    localparam int OUT_W         = 16;
    localparam int CFG_AW        = 3;
    localparam int CFG_DW        = 16;

    typedef enum logic [3:0] {
        PH_IDLE           = 4'd0,
        PH_START_LOW      = 4'd1,
        PH_START_HIGH     = 4'd2,
        PH_RESP_SAMPLE    = 4'd3,
        PH_RESP_CONFIRM   = 4'd4,
        PH_RESP_HIGH_WAIT = 4'd5,
        PH_BIT_WAIT_HIGH  = 4'd6,
        PH_BIT_SAMPLE     = 4'd7,
        PH_BIT_WAIT_LOW   = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        DRV_RELEASE = 2'd0,
        DRV_LOW     = 2'd1,
        DRV_HIGH    = 2'd2
    } drive_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_START_LOW       = 3'd0,
        REG_START_HIGH      = 3'd1,
        REG_RESP_SAMPLE     = 3'd2,
        REG_RESP_CONFIRM    = 3'd3,
        REG_BIT_SAMPLE      = 3'd4,
        REG_EDGE_TIMEOUT    = 3'd5
    } reg_index_t;

    localparam logic [15:0] START_LOW_RST    = 16'd20000;
    localparam logic [7:0]  START_HIGH_RST   = 8'd30;
    localparam logic [7:0]  RESP_SAMPLE_RST  = 8'd40;
    localparam logic [7:0]  RESP_CONFIRM_RST = 8'd80;
    localparam logic [7:0]  BIT_SAMPLE_RST   = 8'd40;
    localparam logic [15:0] EDGE_TIMEOUT_RST = 16'd2000;

    typedef struct packed {
        logic [15:0] start_low_us;
        logic [7:0]  start_high_us;
        logic [7:0]  response_sample_us;
        logic [7:0]  response_confirm_us;
        logic [7:0]  bit_sample_us;
        logic [15:0] edge_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] tick_count;
        logic [2:0]  bit_index;
        logic [7:0]  shift_byte;
        logic        response_flag;
    } state_t;

    typedef struct packed {
        logic [1:0] line_drive;
        logic       busy_res;
        logic       done_res;
        logic       response_ok;
        logic [7:0] data_byte;
    } result_t;

endpackage

>>> src/dhtwm_step.sv
// ----------------------------------------------------------------------------
// dhtwm_step
// Next-state and result logic for one microsecond tick of the line protocol.
// ----------------------------------------------------------------------------
module dhtwm_step (
    input  dhtwm_pkg::cfg_t    cfg,
    input  dhtwm_pkg::state_t  cur,
    input  logic [1:0]         cmd,
    input  logic               line_level,
    output dhtwm_pkg::state_t  nxt,
    output dhtwm_pkg::result_t res
);
    import dhtwm_pkg::*;

    state_t      st;
    logic [15:0] cnt_inc;
    logic [15:0] dur;
    logic        t_end;
    logic [3:0]  bit_n;
    logic [2:0]  bit_pos;
    drive_t      drive;
    logic        done;

    // duration of the timed phase currently running
    always_comb begin
        case (st.phase)
            PH_START_LOW:      dur = cfg.start_low_us;
            PH_START_HIGH:     dur = {8'd0, cfg.start_high_us};
            PH_RESP_SAMPLE:    dur = {8'd0, cfg.response_sample_us};
            PH_RESP_CONFIRM:   dur = {8'd0, cfg.response_confirm_us};
            PH_BIT_SAMPLE:     dur = {8'd0, cfg.bit_sample_us};
            default:           dur = cfg.edge_timeout_ticks;
        endcase
    end

    always_comb begin
        st = cur;
        if (cur.phase == PH_IDLE) begin
            if (cmd == CMD_START) begin
                st.response_flag = 1'b0;
                st.phase         = PH_START_LOW;
                st.tick_count    = 16'd0;
            end else if (cmd == CMD_READ) begin
                st.bit_index  = 3'd0;
                st.phase      = PH_BIT_WAIT_HIGH;
                st.tick_count = 16'd0;
            end
        end
    end

    assign cnt_inc = st.tick_count + 16'd1;
    assign t_end   = (cnt_inc >= dur) || (cnt_inc == 16'd0);
    assign bit_n   = {1'b0, st.bit_index} + 4'd1;
    assign bit_pos = 3'd7 - st.bit_index;

    always_comb begin
        nxt   = st;
        drive = DRV_RELEASE;
        done  = 1'b0;
        case (st.phase)
            PH_IDLE: begin
                nxt.tick_count = st.tick_count;
            end
            PH_START_LOW: begin
                drive          = DRV_LOW;
                nxt.tick_count = cnt_inc;
                if (t_end) begin
                    nxt.phase      = PH_START_HIGH;
                    nxt.tick_count = 16'd0;
                end
            end
            PH_START_HIGH: begin
                drive          = DRV_HIGH;
                nxt.tick_count = cnt_inc;
                if (t_end) begin
                    nxt.phase      = PH_RESP_SAMPLE;
                    nxt.tick_count = 16'd0;
                end
            end
            PH_RESP_SAMPLE: begin
                nxt.tick_count = cnt_inc;
                if (t_end) begin
                    nxt.phase      = line_level ? PH_RESP_HIGH_WAIT : PH_RESP_CONFIRM;
                    nxt.tick_count = 16'd0;
                end
            end
            PH_RESP_CONFIRM: begin
                nxt.tick_count = cnt_inc;
                if (t_end) begin
                    if (line_level) begin
                        nxt.response_flag = 1'b1;
                    end
                    nxt.phase      = PH_RESP_HIGH_WAIT;
                    nxt.tick_count = 16'd0;
                end
            end
            PH_RESP_HIGH_WAIT: begin
                // edge check wins before the timeout counter moves
                if (!line_level || t_end) begin
                    nxt.phase      = PH_IDLE;
                    nxt.tick_count = 16'd0;
                    done           = 1'b1;
                end else begin
                    nxt.tick_count = cnt_inc;
                end
            end
            PH_BIT_WAIT_HIGH: begin
                if (line_level || t_end) begin
                    nxt.phase      = PH_BIT_SAMPLE;
                    nxt.tick_count = 16'd0;
                end else begin
                    nxt.tick_count = cnt_inc;
                end
            end
            PH_BIT_SAMPLE: begin
                nxt.tick_count = cnt_inc;
                if (t_end) begin
                    nxt.shift_byte[bit_pos] = line_level;
                    nxt.phase      = PH_BIT_WAIT_LOW;
                    nxt.tick_count = 16'd0;
                end
            end
            PH_BIT_WAIT_LOW: begin
                if (!line_level || t_end) begin
                    nxt.tick_count = 16'd0;
                    if (bit_n >= 4'(BITS_PER_READ)) begin
                        nxt.bit_index = 3'd0;
                        nxt.phase     = PH_IDLE;
                        done          = 1'b1;
                    end else begin
                        nxt.bit_index = bit_n[2:0];
                        nxt.phase     = PH_BIT_WAIT_HIGH;
                    end
                end else begin
                    nxt.tick_count = cnt_inc;
                end
            end
            default: begin
                nxt.phase      = PH_IDLE;
                nxt.tick_count = 16'd0;
            end
        endcase
    end

    assign res.line_drive  = drive;
    assign res.busy_res    = (nxt.phase != PH_IDLE);
    assign res.done_res    = done;
    assign res.response_ok = nxt.response_flag;
    assign res.data_byte   = nxt.shift_byte;

endmodule

>>> src/humidity_sensor_wire_master_unit.sv
// ----------------------------------------------------------------------------
// humidity_sensor_wire_master_unit
// Master side of a single-wire humidity sensor link, one tick per transfer.
// ----------------------------------------------------------------------------
// Each input transfer's result is registered into the output register.
// Throughput: one tick per cycle unless m_tready stalls the output; the protocol
// state register and the output register both update on every accepted transfer.
// Reset: aresetn is synchronous, active low; phase returns to idle, counters and
// captured byte clear, configuration registers return to their defaults.
module humidity_sensor_wire_master_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dhtwm_pkg::IN_W-1:0]       s_tdata,   // cmd[1:0], line_level[2]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dhtwm_pkg::OUT_W-1:0]      m_tdata,   // line_drive[1:0], busy_res[2],
                                                        // done_res[3], response_ok[4],
                                                        // data_byte[12:5]
    input  logic                             cfg_we,
    input  logic [dhtwm_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [dhtwm_pkg::CFG_DW-1:0]     cfg_wdata
);
    import dhtwm_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    m_valid_reg;
    logic    s_xfer;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_us        <= START_LOW_RST;
            cfg_reg.start_high_us       <= START_HIGH_RST;
            cfg_reg.response_sample_us  <= RESP_SAMPLE_RST;
            cfg_reg.response_confirm_us <= RESP_CONFIRM_RST;
            cfg_reg.bit_sample_us       <= BIT_SAMPLE_RST;
            cfg_reg.edge_timeout_ticks  <= EDGE_TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_START_LOW:    cfg_reg.start_low_us        <= cfg_wdata;
                REG_START_HIGH:   cfg_reg.start_high_us       <= cfg_wdata[7:0];
                REG_RESP_SAMPLE:  cfg_reg.response_sample_us  <= cfg_wdata[7:0];
                REG_RESP_CONFIRM: cfg_reg.response_confirm_us <= cfg_wdata[7:0];
                REG_BIT_SAMPLE:   cfg_reg.bit_sample_us       <= cfg_wdata[7:0];
                REG_EDGE_TIMEOUT: cfg_reg.edge_timeout_ticks  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    dhtwm_step u_step (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .cmd        (s_tdata[1:0]),
        .line_level (s_tdata[2]),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= PH_IDLE;
            state_reg.tick_count    <= 16'd0;
            state_reg.bit_index     <= 3'd0;
            state_reg.shift_byte    <= 8'd0;
            state_reg.response_flag <= 1'b0;
            m_valid_reg             <= 1'b0;
        end else begin
            if (s_xfer) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, res_reg.data_byte, res_reg.response_ok, res_reg.done_res,
                       res_reg.busy_res, res_reg.line_drive};

    // a finishing tick never reports the sequence as still running
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done and busy set on the same result");

    // the line is only driven while a start sequence is active
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != DRV_RELEASE) |-> m_tdata[2])
        else $error("line driven outside a sequence");

    // an idle protocol state keeps a clear tick counter
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_IDLE) |-> (state_reg.tick_count == 16'd0))
        else $error("tick counter running in idle");

    // a held result is not overwritten while the consumer stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(res_reg)))
        else $error("stalled result changed");

endmodule
